// ----- rtl/pts_pkg.sv -----
`default_nettype none
package pts_pkg;

  localparam int DEPTH = 64;
  localparam int AW = $clog2(DEPTH);
  localparam int SUM_W = 32 + AW;
  localparam int NUM_W = 56;

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_SET   = 3'd1;
  localparam logic [2:0] OP_GET   = 3'd2;
  localparam logic [2:0] OP_SPIKE = 3'd3;
  localparam logic [2:0] OP_NORM  = 3'd4;
  localparam logic [2:0] OP_SORT  = 3'd5;

  localparam logic [1:0] KERN_LIN = 2'd1;
  localparam logic [1:0] KERN_ELL = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef logic [31:0] prob_t;

endpackage
`default_nettype wire

// ----- rtl/probability_table_spike_sort.sv -----
`default_nettype none
// probability table with spike kernels, normalize and sorted readout
//
// input channel: a command beat (in_operation and its operands) is taken
// at a clock edge where start is high and busy is low. a command that leaves
// the idle state then holds busy high until its last result has been issued.
// result channel: each result beat sits on the out_ ports for exactly one
// cycle, marked by out_valid; out_last flags the final beat of a command.
// the receiver cannot stall, so no result is ever held back.
// clear, set, unknown codes, out-of-range get, a spike wholly past the table
// and a sort of an empty table answer in the cycle after the command is taken;
// get reads the table in S_GET_RD and answers from S_GET_OUT. add spike walks
// its index range one entry at a time through a shared multiplier, a 24-step
// square root (ellipse only) and a shared 56-step restoring divider (radius 0
// skips them). normalize sums the table, then divides each present entry; sort
// is a selection sort, one full scan per emitted beat. the memory has one read port.
// reset clears the present marks at once, so the table reads empty;
// absent entries read as zero, and no clearing pass is needed.
module probability_table_spike_sort (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_operation,
  input  wire logic [11:0] in_value,
  input  wire logic [31:0] in_probability,
  input  wire logic [7:0]  in_radius,
  input  wire logic [1:0]  in_kernel,
  input  wire logic        in_ascending,
  output logic             out_valid,
  output logic [11:0]      out_value,
  output logic [31:0]      out_probability,
  output logic [1:0]       out_status,
  output logic             out_last
);

  localparam int AW = pts_pkg::AW;
  localparam int DEPTH = pts_pkg::DEPTH;
  localparam int SUM_W = pts_pkg::SUM_W;
  localparam int NUM_W = pts_pkg::NUM_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [5:0] DIV_LAST = 6'(NUM_W - 1);
  localparam logic [5:0] SQ_LAST = 6'd23;

  // sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_GET_RD  = 5'd1;
  localparam logic [4:0] S_GET_OUT = 5'd2;
  localparam logic [4:0] S_SP_R2   = 5'd3;
  localparam logic [4:0] S_SP_R2C  = 5'd4;
  localparam logic [4:0] S_SP_IDX  = 5'd5;
  localparam logic [4:0] S_SP_LIN  = 5'd6;
  localparam logic [4:0] S_SP_SQS  = 5'd7;
  localparam logic [4:0] S_SP_SQ   = 5'd8;
  localparam logic [4:0] S_SP_PS   = 5'd9;
  localparam logic [4:0] S_SP_PSC  = 5'd10;
  localparam logic [4:0] S_DIV     = 5'd11;
  localparam logic [4:0] S_SP_RD   = 5'd12;
  localparam logic [4:0] S_SP_WR   = 5'd13;
  localparam logic [4:0] S_NS_RD   = 5'd14;
  localparam logic [4:0] S_NS_ACC  = 5'd15;
  localparam logic [4:0] S_NM_RD   = 5'd16;
  localparam logic [4:0] S_NM_SET  = 5'd17;
  localparam logic [4:0] S_NM_WR   = 5'd18;
  localparam logic [4:0] S_SO_BEG  = 5'd19;
  localparam logic [4:0] S_SO_RD   = 5'd20;
  localparam logic [4:0] S_SO_CMP  = 5'd21;
  localparam logic [4:0] S_SO_EMIT = 5'd22;

  logic [4:0]       state_r;
  logic [2:0]       op_r;
  logic [11:0]      val_r;
  logic [31:0]      p_r;
  logic [7:0]       r_r;
  logic [1:0]       kern_r;
  logic             asc_r;
  logic [1:0]       st_r;
  logic [AW-1:0]    idx_r;
  logic [AW-1:0]    end_r;
  logic [15:0]      r2_r;
  logic [DEPTH-1:0] present_r;
  logic [DEPTH-1:0] taken_r;
  logic [AW-1:0]    best_r;
  logic [31:0]      bestp_r;
  logic             have_r;
  logic [SUM_W-1:0] sum_r;

  // shared divider, square root and multiplier
  logic [SUM_W:0]   rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [SUM_W-1:0] den_r;
  logic [5:0]       cnt_r;
  logic [47:0]      sx_r;
  logic [47:0]      sres_r;
  logic [47:0]      sbit_r;
  logic [NUM_W-1:0] prod_r;
  logic [31:0]      mul_a;
  logic [23:0]      mul_b;

  // table memory
  pts_pkg::prob_t   mem [DEPTH];
  pts_pkg::prob_t   rd_data_r;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  pts_pkg::prob_t   mem_wd;

  logic             out_valid_r;
  logic [11:0]      out_value_r;
  logic [31:0]      out_prob_r;
  logic [1:0]       out_status_r;
  logic             out_last_r;

  logic             accept;
  logic             in_range;
  logic [11:0]      lo;
  logic [12:0]      hi;
  logic [11:0]      delta;
  logic [7:0]       d8;
  logic [SUM_W:0]   trial;
  logic             trial_ge;
  logic [47:0]      sq_t;
  logic [31:0]      old_p;
  logic [32:0]      sat_sum;
  logic [31:0]      share;
  logic             better;
  logic [DEPTH-1:0] taken_nxt;

  assign busy = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign in_range = (in_value < 12'(DEPTH));
  assign lo = (in_value > {4'd0, in_radius}) ? in_value - {4'd0, in_radius} : 12'd0;
  assign hi = {1'b0, in_value} + {5'd0, in_radius};

  // distance of the current index from the spike center (at most radius)
  assign delta = ({{(12-AW){1'b0}}, idx_r} > val_r) ? {{(12-AW){1'b0}}, idx_r} - val_r
                                                  : val_r - {{(12-AW){1'b0}}, idx_r};
  assign d8 = delta[7:0];

  // one restoring divide step
  assign trial = {rem_r[SUM_W-1:0], quo_r[NUM_W-1]};
  assign trial_ge = (trial >= {1'b0, den_r});

  // one square root step
  assign sq_t = sres_r + sbit_r;

  // saturating accumulate of the spike share
  assign share = (r_r == 8'd0) ? p_r : quo_r[31:0];
  assign old_p = present_r[idx_r] ? rd_data_r : 32'd0;
  assign sat_sum = {1'b0, old_p} + {1'b0, share};

  // selection compare, strict so ties keep the lower index
  assign better = !have_r || (asc_r ? (rd_data_r < bestp_r) : (rd_data_r > bestp_r));
  always_comb begin
    taken_nxt = taken_r;
    taken_nxt[best_r] = 1'b1;
  end

  always_comb begin
    mul_a = 32'd0;
    mul_b = 24'd0;
    unique case (state_r)
      S_SP_R2: begin
        mul_a = {24'd0, r_r};
        mul_b = {16'd0, r_r};
      end
      S_SP_IDX: begin
        if (kern_r == pts_pkg::KERN_LIN) begin
          mul_a = p_r;
          mul_b = {16'd0, r_r - d8};
        end else begin
          mul_a = {24'd0, d8};
          mul_b = {16'd0, d8};
        end
      end
      S_SP_PS: begin
        mul_a = p_r;
        mul_b = sres_r[23:0];
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 24'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= NUM_W'(mul_a) * NUM_W'(mul_b);
  end

  // memory write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_r;
    mem_wd = quo_r[31:0];
    unique case (state_r)
      S_IDLE: begin
        mem_we = accept && (in_operation == pts_pkg::OP_SET) && in_range;
        mem_wa = in_value[AW-1:0];
        mem_wd = in_probability;
      end
      S_SP_WR: begin
        mem_we = 1'b1;
        mem_wd = sat_sum[32] ? 32'hFFFF_FFFF : sat_sum[31:0];
      end
      S_NM_WR: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      present_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r <= in_operation;
            val_r <= in_value;
            p_r <= in_probability;
            r_r <= in_radius;
            kern_r <= in_kernel;
            asc_r <= in_ascending;
            out_value_r <= 12'd0;
            out_prob_r <= 32'd0;
            out_status_r <= pts_pkg::ST_OK;
            out_last_r <= 1'b1;
            priority case (in_operation)
              pts_pkg::OP_CLEAR: begin
                present_r <= '0;
                out_valid_r <= 1'b1;
              end
              pts_pkg::OP_SET: begin
                out_value_r <= in_value;
                out_valid_r <= 1'b1;
                if (in_range) begin
                  present_r[in_value[AW-1:0]] <= 1'b1;
                  out_prob_r <= in_probability;
                end else begin
                  out_status_r <= pts_pkg::ST_RANGE;
                end
              end
              pts_pkg::OP_GET: begin
                out_value_r <= in_value;
                if (in_range) begin
                  idx_r <= in_value[AW-1:0];
                  state_r <= S_GET_RD;
                end else begin
                  out_status_r <= pts_pkg::ST_RANGE;
                  out_valid_r <= 1'b1;
                end
              end
              pts_pkg::OP_SPIKE: begin
                // indices past the table are dropped, flagged when any exist
                st_r <= (hi >= 13'(DEPTH)) ? pts_pkg::ST_RANGE : pts_pkg::ST_OK;
                idx_r <= lo[AW-1:0];
                end_r <= (hi >= 13'(DEPTH)) ? LAST_IDX : hi[AW-1:0];
                if (lo >= 12'(DEPTH)) begin
                  out_value_r <= in_value;
                  out_status_r <= pts_pkg::ST_RANGE;
                  out_valid_r <= 1'b1;
                end else begin
                  state_r <= S_SP_R2;
                end
              end
              pts_pkg::OP_NORM: begin
                idx_r <= '0;
                sum_r <= '0;
                state_r <= S_NS_RD;
              end
              pts_pkg::OP_SORT: begin
                if (present_r == '0) begin
                  out_status_r <= pts_pkg::ST_EMPTY;
                  out_valid_r <= 1'b1;
                end else begin
                  taken_r <= ~present_r;
                  state_r <= S_SO_BEG;
                end
              end
              default: begin
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end

        S_GET_RD: begin
          state_r <= S_GET_OUT;
        end
        S_GET_OUT: begin
          out_prob_r <= present_r[idx_r] ? rd_data_r : 32'd0;
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end

        // spike: radius squared once, then one pass per index
        S_SP_R2: begin
          state_r <= S_SP_R2C;
        end
        S_SP_R2C: begin
          r2_r <= prod_r[15:0];
          state_r <= S_SP_IDX;
        end
        S_SP_IDX: begin
          if (r_r == 8'd0) begin
            state_r <= S_SP_RD;
          end else if (kern_r == pts_pkg::KERN_LIN) begin
            state_r <= S_SP_LIN;
          end else if (kern_r == pts_pkg::KERN_ELL) begin
            state_r <= S_SP_SQS;
          end else begin
            rem_r <= '0;
            quo_r <= NUM_W'(p_r);
            den_r <= SUM_W'({r_r, 1'b0});
            cnt_r <= '0;
            state_r <= S_DIV;
          end
        end
        S_SP_LIN: begin
          rem_r <= '0;
          quo_r <= prod_r;
          den_r <= SUM_W'({r2_r, 1'b0});
          cnt_r <= '0;
          state_r <= S_DIV;
        end
        S_SP_SQS: begin
          sx_r <= {r2_r - prod_r[15:0], 32'd0};
          sres_r <= '0;
          sbit_r <= 48'd1 << 46;
          cnt_r <= '0;
          state_r <= S_SP_SQ;
        end
        S_SP_SQ: begin
          if (sx_r >= sq_t) begin
            sx_r <= sx_r - sq_t;
            sres_r <= (sres_r >> 1) + sbit_r;
          end else begin
            sres_r <= sres_r >> 1;
          end
          sbit_r <= sbit_r >> 2;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == SQ_LAST) begin
            state_r <= S_SP_PS;
          end
        end
        S_SP_PS: begin
          state_r <= S_SP_PSC;
        end
        S_SP_PSC: begin
          rem_r <= '0;
          quo_r <= prod_r;
          den_r <= SUM_W'({r2_r, 17'd0});
          cnt_r <= '0;
          state_r <= S_DIV;
        end

        S_DIV: begin
          rem_r <= trial_ge ? trial - {1'b0, den_r} : trial;
          quo_r <= {quo_r[NUM_W-2:0], trial_ge};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == DIV_LAST) begin
            state_r <= (op_r == pts_pkg::OP_SPIKE) ? S_SP_RD : S_NM_WR;
          end
        end

        S_SP_RD: begin
          state_r <= S_SP_WR;
        end
        S_SP_WR: begin
          present_r[idx_r] <= 1'b1;
          if (idx_r == end_r) begin
            out_value_r <= val_r;
            out_status_r <= st_r;
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + AW'(1);
            state_r <= S_SP_IDX;
          end
        end

        // normalize: sum pass, then one divide per present entry
        S_NS_RD: begin
          state_r <= S_NS_ACC;
        end
        S_NS_ACC: begin
          if (present_r[idx_r]) begin
            sum_r <= sum_r + SUM_W'(rd_data_r);
          end
          if (idx_r == LAST_IDX) begin
            idx_r <= '0;
            if ((sum_r + (present_r[idx_r] ? SUM_W'(rd_data_r) : '0)) == '0) begin
              out_status_r <= pts_pkg::ST_EMPTY;
              out_valid_r <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_NM_RD;
            end
          end else begin
            idx_r <= idx_r + AW'(1);
            state_r <= S_NS_RD;
          end
        end
        S_NM_RD: begin
          state_r <= S_NM_SET;
        end
        S_NM_SET: begin
          if (present_r[idx_r]) begin
            rem_r <= '0;
            quo_r <= NUM_W'({rd_data_r, 16'd0});
            den_r <= sum_r;
            cnt_r <= '0;
            state_r <= S_DIV;
          end else if (idx_r == LAST_IDX) begin
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + AW'(1);
            state_r <= S_NM_RD;
          end
        end
        S_NM_WR: begin
          if (idx_r == LAST_IDX) begin
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + AW'(1);
            state_r <= S_NM_RD;
          end
        end

        // sort: one full scan per emitted beat
        S_SO_BEG: begin
          idx_r <= '0;
          have_r <= 1'b0;
          state_r <= S_SO_RD;
        end
        S_SO_RD: begin
          state_r <= S_SO_CMP;
        end
        S_SO_CMP: begin
          if (!taken_r[idx_r] && better) begin
            best_r <= idx_r;
            bestp_r <= rd_data_r;
            have_r <= 1'b1;
          end
          if (idx_r == LAST_IDX) begin
            state_r <= S_SO_EMIT;
          end else begin
            idx_r <= idx_r + AW'(1);
            state_r <= S_SO_RD;
          end
        end
        S_SO_EMIT: begin
          taken_r <= taken_nxt;
          out_value_r <= 12'(best_r);
          out_prob_r <= bestp_r;
          out_status_r <= pts_pkg::ST_OK;
          out_last_r <= &taken_nxt;
          out_valid_r <= 1'b1;
          state_r <= (&taken_nxt) ? S_IDLE : S_SO_BEG;
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_probability = out_prob_r;
  assign out_status = out_status_r;
  assign out_last = out_last_r;

endmodule
`default_nettype wire

// ----- verif/probability_table_spike_sort_tb.sv -----
`default_nettype none
module probability_table_spike_sort_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // codes the package leaves unnamed
  localparam logic [2:0] OP_RSVD_A = 3'd6;
  localparam logic [2:0] OP_RSVD_B = 3'd7;
  localparam logic [1:0] KERN_UNI = 2'd0;
  localparam logic [1:0] KERN_UNI_ALT = 2'd3;

  // longest quiet stretch: an ellipse spike walks at most 64 entries
  localparam int QUIET_LIMIT = 30000;
  localparam int TAIL_CYCLES = 300;

  typedef struct packed {
    logic [11:0] value;
    pts_pkg::prob_t prob;
    logic [1:0] status;
    logic last;
  } beat_t;

  // table predictor plus queue of expected result beats
  class pts_scoreboard;
    pts_pkg::prob_t tbl[pts_pkg::DEPTH];
    bit mark[pts_pkg::DEPTH];
    beat_t expected_beats[$];
    int errors;
    int beats_seen;
    int cmds_seen;

    function new();
      wipe();
      errors = 0;
      beats_seen = 0;
      cmds_seen = 0;
    endfunction

    function void wipe();
      for (int i = 0; i < pts_pkg::DEPTH; i++) begin
        tbl[i] = '0;
        mark[i] = 1'b0;
      end
    endfunction

    function void push(logic [11:0] v, pts_pkg::prob_t p, logic [1:0] st, logic lst);
      beat_t b;
      b.value = v;
      b.prob = p;
      b.status = st;
      b.last = lst;
      expected_beats.insert(expected_beats.size(), b);
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res = '0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // share of the spike weight landing at distance d from the center
    function logic [63:0] spike_share(logic [63:0] w, int unsigned r, int unsigned d,
                                      logic [1:0] kern);
      logic [63:0] den;
      logic [63:0] q;
      den = 64'd2 * r * r;
      if (r == 0) return w;
      if (kern == pts_pkg::KERN_LIN) return (w * (r - d)) / den;
      if (kern == pts_pkg::KERN_ELL) begin
        q = (64'(r) * r - 64'(d) * d) << 32;
        return (w * int_sqrt(q)) / (den << 16);
      end
      return w / (64'd2 * r);
    endfunction

    function void note(logic [2:0] op, logic [11:0] v, pts_pkg::prob_t p, logic [7:0] r,
                       logic [1:0] kern, logic asc);
      int unsigned lo, hi, d;
      logic [1:0] st;
      logic [63:0] acc;
      int total, best;
      bit taken[pts_pkg::DEPTH];
      cmds_seen++;
      case (op)
        pts_pkg::OP_CLEAR: begin
          wipe();
          push('0, '0, pts_pkg::ST_OK, 1'b1);
        end
        pts_pkg::OP_SET: begin
          if (v < pts_pkg::DEPTH) begin
            tbl[v] = p;
            mark[v] = 1'b1;
            push(v, p, pts_pkg::ST_OK, 1'b1);
          end else begin
            push(v, '0, pts_pkg::ST_RANGE, 1'b1);
          end
        end
        pts_pkg::OP_GET: begin
          if (v < pts_pkg::DEPTH) push(v, mark[v] ? tbl[v] : '0, pts_pkg::ST_OK, 1'b1);
          else push(v, '0, pts_pkg::ST_RANGE, 1'b1);
        end
        pts_pkg::OP_SPIKE: begin
          lo = (v > r) ? v - r : 0;
          hi = v + r;
          st = pts_pkg::ST_OK;
          for (int unsigned i = lo; i <= hi; i++) begin
            d = (i > v) ? i - v : v - i;
            if (i >= pts_pkg::DEPTH) begin
              st = pts_pkg::ST_RANGE;
            end else begin
              acc = 64'(tbl[i]) + spike_share(64'(p), r, d, kern);
              tbl[i] = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
              mark[i] = 1'b1;
            end
          end
          push(v, '0, st, 1'b1);
        end
        pts_pkg::OP_NORM: begin
          acc = '0;
          for (int i = 0; i < pts_pkg::DEPTH; i++) if (mark[i]) acc += tbl[i];
          if (acc == 0) begin
            push('0, '0, pts_pkg::ST_EMPTY, 1'b1);
          end else begin
            for (int i = 0; i < pts_pkg::DEPTH; i++)
              if (mark[i]) tbl[i] = 32'((64'(tbl[i]) << 16) / acc);
            push('0, '0, pts_pkg::ST_OK, 1'b1);
          end
        end
        pts_pkg::OP_SORT: begin
          total = 0;
          for (int i = 0; i < pts_pkg::DEPTH; i++) begin
            taken[i] = !mark[i];
            if (mark[i]) total++;
          end
          if (total == 0) push('0, '0, pts_pkg::ST_EMPTY, 1'b1);
          for (int k = 0; k < total; k++) begin
            best = -1;
            for (int i = 0; i < pts_pkg::DEPTH; i++) begin
              if (!taken[i] && (best < 0 ||
                  (asc ? tbl[i] < tbl[best] : tbl[i] > tbl[best])))
                best = i;
            end
            taken[best] = 1'b1;
            push(12'(best), tbl[best], pts_pkg::ST_OK, k == total - 1);
          end
        end
        default: push('0, '0, pts_pkg::ST_OK, 1'b1);
      endcase
    endfunction

    function void check(beat_t got);
      beat_t want;
      beats_seen++;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat value=%0d prob=%h status=%0d last=%0b",
                 $time, got.value, got.prob, got.status, got.last);
        return;
      end
      want = expected_beats.pop_front();
      if (got.value !== want.value) begin
        errors++;
        $display("%0t: value expected %0d actual %0d", $time, want.value, got.value);
      end
      if (got.prob !== want.prob) begin
        errors++;
        $display("%0t: probability expected %h actual %h", $time, want.prob, got.prob);
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
      end
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

  logic clk, rst_n, start, busy;
  logic [2:0] in_operation;
  logic [11:0] in_value;
  logic [31:0] in_probability;
  logic [7:0] in_radius;
  logic [1:0] in_kernel;
  logic in_ascending;
  logic out_valid, out_last;
  logic [11:0] out_value;
  logic [31:0] out_probability;
  logic [1:0] out_status;

  pts_scoreboard sb;
  int quiet_cycles;
  int idle_pct;

  probability_table_spike_sort dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_value(in_value),
    .in_probability(in_probability), .in_radius(in_radius),
    .in_kernel(in_kernel), .in_ascending(in_ascending),
    .out_valid(out_valid), .out_value(out_value),
    .out_probability(out_probability), .out_status(out_status),
    .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result beats are checked as they appear; the block never holds them
  always @(posedge clk) begin
    beat_t got;
    if (rst_n && out_valid) begin
      got.value = out_value;
      got.prob = out_probability;
      got.status = out_status;
      got.last = out_last;
      sb.check(got);
    end
  end

  // watchdog: any accepted command or result beat resets the count
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("probability_table_spike_sort: mismatch");
        $finish;
      end
    end
  end

  // present one command beat and hold it until the block takes it;
  // start stays high afterwards so back-to-back beats need no gap
  task automatic send_cmd(logic [2:0] op, logic [11:0] v, pts_pkg::prob_t p,
                          logic [7:0] r, logic [1:0] kern, logic asc);
    @(negedge clk);
    in_operation = op;
    in_value = v;
    in_probability = p;
    in_radius = r;
    in_kernel = kern;
    in_ascending = asc;
    start = 1'b1;
    do @(posedge clk); while (busy);
    sb.note(op, v, p, r, kern, asc);
  endtask

  // random sender gaps: start is dropped for as long as a roll stays under idle_pct
  task automatic sender_gap();
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // weighted random command: mostly sets and small spikes keep the table busy
  task automatic rand_cmd();
    int roll;
    logic [2:0] op;
    logic [11:0] v;
    pts_pkg::prob_t p;
    logic [7:0] r;
    roll = $urandom_range(99);
    v = $urandom_range(9) == 0 ? 12'($urandom) : 12'($urandom_range(70));
    p = $urandom_range(3) == 0 ? pts_pkg::prob_t'($urandom_range(65536))
                               : pts_pkg::prob_t'($urandom);
    r = 8'($urandom_range(6));
    if ($urandom_range(6) == 0) r = 8'($urandom_range(40));
    if ($urandom_range(40) == 0) r = 8'($urandom);
    if (roll < 4) op = pts_pkg::OP_CLEAR;
    else if (roll < 34) op = pts_pkg::OP_SET;
    else if (roll < 52) op = pts_pkg::OP_GET;
    else if (roll < 76) op = pts_pkg::OP_SPIKE;
    else if (roll < 84) op = pts_pkg::OP_NORM;
    else if (roll < 97) op = pts_pkg::OP_SORT;
    else op = $urandom_range(1) ? OP_RSVD_A : OP_RSVD_B;
    send_cmd(op, v, p, r, 2'($urandom), 1'($urandom));
  endtask

  initial begin
    int pcts[4];
    sb = new();
    pcts = '{0, 61, 0, 36};
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = pts_pkg::OP_CLEAR;
    in_value = '0;
    in_probability = '0;
    in_radius = '0;
    in_kernel = KERN_UNI;
    in_ascending = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty table, field extremes, every kernel, ties, saturation
    send_cmd(pts_pkg::OP_SORT, 12'd0, 32'd0, 8'd0, KERN_UNI, 1'b0);
    send_cmd(pts_pkg::OP_NORM, 12'd0, 32'd0, 8'd0, KERN_UNI, 1'b0);
    send_cmd(pts_pkg::OP_SET, 12'd0, 32'hFFFF_FFFF, 8'd0, KERN_UNI, 1'b0);
    send_cmd(pts_pkg::OP_SET, 12'd63, 32'd0, 8'd0, KERN_UNI, 1'b0);
    send_cmd(pts_pkg::OP_SET, 12'd64, 32'h1234_5678, 8'd0, KERN_UNI, 1'b0);
    send_cmd(pts_pkg::OP_SET, 12'hFFF, 32'hFFFF_FFFF, 8'hFF, KERN_UNI_ALT, 1'b1);
    send_cmd(pts_pkg::OP_GET, 12'd63, 32'd0, 8'd0, KERN_UNI, 1'b0);
    send_cmd(pts_pkg::OP_GET, 12'd5, 32'd0, 8'd0, KERN_UNI, 1'b0);
    send_cmd(pts_pkg::OP_GET, 12'hFFF, 32'd0, 8'd0, KERN_UNI, 1'b0);
    send_cmd(pts_pkg::OP_SPIKE, 12'd0, 32'hFFFF_FFFF, 8'd0, KERN_UNI, 1'b0);
    send_cmd(pts_pkg::OP_SPIKE, 12'd10, 32'h0001_0000, 8'd3, KERN_UNI, 1'b0);
    send_cmd(pts_pkg::OP_SPIKE, 12'd20, 32'h0001_0000, 8'd3, pts_pkg::KERN_LIN, 1'b0);
    send_cmd(pts_pkg::OP_SPIKE, 12'd30, 32'h0001_0000, 8'd3, pts_pkg::KERN_ELL, 1'b0);
    send_cmd(pts_pkg::OP_SPIKE, 12'd40, 32'h0001_0000, 8'd3, KERN_UNI_ALT, 1'b0);
    send_cmd(pts_pkg::OP_SPIKE, 12'd62, 32'hFFFF_FFFF, 8'd4, pts_pkg::KERN_ELL, 1'b0);
    send_cmd(pts_pkg::OP_SPIKE, 12'hFFF, 32'h8000_0001, 8'hFF, pts_pkg::KERN_LIN, 1'b1);
    send_cmd(pts_pkg::OP_SET, 12'd50, 32'h0000_0777, 8'd0, KERN_UNI, 1'b0);
    send_cmd(pts_pkg::OP_SET, 12'd51, 32'h0000_0777, 8'd0, KERN_UNI, 1'b0);
    send_cmd(pts_pkg::OP_SORT, 12'd0, 32'd0, 8'd0, KERN_UNI, 1'b0);
    send_cmd(pts_pkg::OP_SORT, 12'd0, 32'd0, 8'd0, KERN_UNI, 1'b1);
    send_cmd(pts_pkg::OP_NORM, 12'd0, 32'd0, 8'd0, KERN_UNI, 1'b0);
    send_cmd(pts_pkg::OP_SORT, 12'd0, 32'd0, 8'd0, KERN_UNI, 1'b0);
    send_cmd(OP_RSVD_A, 12'hFFF, 32'hFFFF_FFFF, 8'hFF, pts_pkg::KERN_ELL, 1'b1);
    send_cmd(OP_RSVD_B, 12'd1, 32'd1, 8'd1, pts_pkg::KERN_LIN, 1'b0);
    send_cmd(pts_pkg::OP_CLEAR, 12'hFFF, 32'hFFFF_FFFF, 8'hFF, KERN_UNI_ALT, 1'b1);
    // sender holds off here until every result has come back
    drain();

    // random phases with sender gap rates of 0, 61, 0 and 36 percent
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = pcts[ph];
      for (int n = 0; n < 65; n++) begin
        sender_gap();
        rand_cmd();
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors += sb.pending();
      $display("%0t: %0d expected beats never arrived", $time, sb.pending());
    end
    $display("ran %0d commands (all ops, kernels, range and empty cases), checked %0d beats",
             sb.cmds_seen, sb.beats_seen);
    if (sb.errors == 0) begin
      $display("probability_table_spike_sort: match");
    end else begin
      $display("probability_table_spike_sort: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
